/* hw/rtl/rtbb_pkg.sv */
`timescale 1ns / 1ps

package rtbb_pkg;

	localparam int COORD_W  = 32;   // point, shift and result coordinates
	localparam int QUAT_W   = 18;   // quaternion parts, Q2.16
	localparam int MARGIN_W = 31;   // box margin, unsigned
	localparam int FRAC_W   = 16;   // fraction bits of Q16.16
	localparam int CFG_IDX_W = 8;
	localparam int LANES    = 3;    // x, y, z

	localparam int Q_DEPTH = 2;     // front-to-back queue
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z     = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X    = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y    = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z    = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MARGIN = 8'd7;

	localparam logic signed [QUAT_W-1:0] QUAT_ONE = 18'sd65536;

	typedef struct packed {
		logic signed [QUAT_W-1:0]  quat_w;
		logic signed [QUAT_W-1:0]  quat_x;
		logic signed [QUAT_W-1:0]  quat_y;
		logic signed [QUAT_W-1:0]  quat_z;
		logic signed [COORD_W-1:0] shift_x;
		logic signed [COORD_W-1:0] shift_y;
		logic signed [COORD_W-1:0] shift_z;
		logic [MARGIN_W-1:0]       box_margin;
	} cfg_t;

	// what the back end does with a point besides moving it
	typedef struct packed {
		logic include_in_box;
		logic last_point;
	} kind_t;

	typedef struct packed {
		logic [LANES-1:0][COORD_W-1:0] point;
		kind_t                         kind;
	} item_t;

	typedef struct packed {
		logic [LANES-1:0][COORD_W-1:0] box_max;
		logic [LANES-1:0][COORD_W-1:0] box_min;
		logic [LANES-1:0][COORD_W-1:0] moved;
		logic                          box_valid;
	} res_t;

endpackage

/* hw/rtl/rtbb_cfg.sv */
`timescale 1ns / 1ps

module rtbb_cfg import rtbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [COORD_W-1:0]   wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quat_w     <= QUAT_ONE;
			cfg_q.quat_x     <= '0;
			cfg_q.quat_y     <= '0;
			cfg_q.quat_z     <= '0;
			cfg_q.shift_x    <= '0;
			cfg_q.shift_y    <= '0;
			cfg_q.shift_z    <= '0;
			cfg_q.box_margin <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_QUAT_W: begin
					cfg_q.quat_w <= wr_data[QUAT_W-1:0];
				end
				REG_QUAT_X: begin
					cfg_q.quat_x <= wr_data[QUAT_W-1:0];
				end
				REG_QUAT_Y: begin
					cfg_q.quat_y <= wr_data[QUAT_W-1:0];
				end
				REG_QUAT_Z: begin
					cfg_q.quat_z <= wr_data[QUAT_W-1:0];
				end
				REG_SHIFT_X: begin
					cfg_q.shift_x <= wr_data;
				end
				REG_SHIFT_Y: begin
					cfg_q.shift_y <= wr_data;
				end
				REG_SHIFT_Z: begin
					cfg_q.shift_z <= wr_data;
				end
				REG_BOX_MARGIN: begin
					cfg_q.box_margin <= wr_data[MARGIN_W-1:0];
				end
				default: begin
					// unknown index: write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/rtbb_front.sv */
`timescale 1ns / 1ps

module rtbb_front import rtbb_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [LANES*COORD_W-1:0]   in_data,
	input  logic                       in_include,
	input  logic                       in_last,
	output logic                       q_valid,
	input  logic                       q_ready,
	output item_t                      q_item
);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	item_t              item_in;
	logic               push;
	logic               pop;

	// classify: flags become the item kind
	always_comb begin
		item_in                     = '0;
		item_in.point               = in_data;
		item_in.kind.include_in_box = in_include;
		item_in.kind.last_point     = in_last;
	end

	assign in_ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

/* hw/rtl/rtbb_back.sv */
`timescale 1ns / 1ps

module rtbb_back import rtbb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	localparam int PROD1_W = QUAT_W + COORD_W;        // q * p
	localparam int CROSS_W = PROD1_W + 2 - FRAC_W;    // rounded u x v
	localparam int PROD2_W = QUAT_W + CROSS_W;        // q * c
	localparam int SUM_W   = PROD2_W + 4;
	localparam int ROT_W   = SUM_W - FRAC_W;          // rotated, Q26.16
	localparam int WIDE_W  = ROT_W + 1;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_W - 1);

	function automatic logic signed [COORD_W-1:0] sat(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-COORD_W:0] top;
		top = v[WIDE_W-1:COORD_W-1];
		if (top == '0 || top == '1) begin
			return v[COORD_W-1:0];
		end else if (v[WIDE_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

	logic adv;

	logic signed [QUAT_W-1:0]  qw, qx, qy, qz;
	logic signed [COORD_W-1:0] pin   [LANES];
	logic signed [COORD_W-1:0] shift [LANES];
	logic signed [WIDE_W-1:0]  margin;

	// stage 1: first cross-product terms
	logic                      v_s1;
	kind_t                     kind_s1;
	logic signed [COORD_W-1:0] pt_s1 [LANES];
	logic signed [PROD1_W-1:0] pa_s1 [LANES];
	logic signed [PROD1_W-1:0] pb_s1 [LANES];
	// stage 2: c = u x v rounded
	logic                      v_s2;
	kind_t                     kind_s2;
	logic signed [COORD_W-1:0] pt_s2 [LANES];
	logic signed [CROSS_W-1:0] c_s2  [LANES];
	logic signed [SUM_W-1:0]   cdiff [LANES];
	// stage 3: w*c and u x c terms
	logic                      v_s3;
	kind_t                     kind_s3;
	logic signed [COORD_W-1:0] pt_s3 [LANES];
	logic signed [PROD2_W-1:0] wc_s3 [LANES];
	logic signed [PROD2_W-1:0] da_s3 [LANES];
	logic signed [PROD2_W-1:0] db_s3 [LANES];
	// stage 4: rotated point
	logic                      v_s4;
	kind_t                     kind_s4;
	logic signed [ROT_W-1:0]   r_s4  [LANES];
	logic signed [SUM_W-1:0]   sum4  [LANES];
	// stage 5: translated, saturated point
	logic                      v_s5;
	kind_t                     kind_s5;
	logic signed [COORD_W-1:0] m_s5  [LANES];

	logic signed [COORD_W-1:0] run_min_q [LANES];
	logic signed [COORD_W-1:0] run_max_q [LANES];
	logic signed [COORD_W-1:0] nmin      [LANES];
	logic signed [COORD_W-1:0] nmax      [LANES];

	logic out_valid_q;
	res_t res_q;

	// whole pipeline holds while the output register is full and not taken
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_comb begin
		qw = cfg.quat_w;
		qx = cfg.quat_x;
		qy = cfg.quat_y;
		qz = cfg.quat_z;
		shift[0] = cfg.shift_x;
		shift[1] = cfg.shift_y;
		shift[2] = cfg.shift_z;
		margin = WIDE_W'($signed({1'b0, cfg.box_margin}));
		for (int i = 0; i < LANES; i++) begin
			pin[i] = in_item.point[i];
			cdiff[i] = SUM_W'(pa_s1[i]) - SUM_W'(pb_s1[i]) + HALF;
			sum4[i] = (SUM_W'(pt_s3[i]) <<< FRAC_W) + (SUM_W'(wc_s3[i]) <<< 1)
				+ ((SUM_W'(da_s3[i]) - SUM_W'(db_s3[i])) <<< 1) + HALF;
			nmin[i] = (kind_s5.include_in_box && m_s5[i] < run_min_q[i]) ? m_s5[i]
				: run_min_q[i];
			nmax[i] = (kind_s5.include_in_box && m_s5[i] > run_max_q[i]) ? m_s5[i]
				: run_max_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				run_min_q[i] <= '0;
				run_max_q[i] <= '0;
			end
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
			if (v_s5) begin
				for (int i = 0; i < LANES; i++) begin
					run_min_q[i] <= kind_s5.last_point ? '0 : nmin[i];
					run_max_q[i] <= kind_s5.last_point ? '0 : nmax[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= in_item.kind;
			kind_s2 <= kind_s1;
			kind_s3 <= kind_s2;
			kind_s4 <= kind_s3;
			kind_s5 <= kind_s4;
			for (int i = 0; i < LANES; i++) begin
				pt_s1[i] <= pin[i];
				pt_s2[i] <= pt_s1[i];
				pt_s3[i] <= pt_s2[i];
				c_s2[i]  <= CROSS_W'(cdiff[i] >>> FRAC_W);
				wc_s3[i] <= qw * c_s2[i];
				r_s4[i]  <= ROT_W'(sum4[i] >>> FRAC_W);
				m_s5[i]  <= sat(WIDE_W'(r_s4[i]) + WIDE_W'(shift[i]));
			end
			// u x v
			pa_s1[0] <= qy * pin[2];
			pb_s1[0] <= qz * pin[1];
			pa_s1[1] <= qz * pin[0];
			pb_s1[1] <= qx * pin[2];
			pa_s1[2] <= qx * pin[1];
			pb_s1[2] <= qy * pin[0];
			// u x c
			da_s3[0] <= qy * c_s2[2];
			db_s3[0] <= qz * c_s2[1];
			da_s3[1] <= qz * c_s2[0];
			db_s3[1] <= qx * c_s2[2];
			da_s3[2] <= qx * c_s2[1];
			db_s3[2] <= qy * c_s2[0];
			if (v_s5) begin
				res_q.box_valid <= kind_s5.last_point;
				for (int i = 0; i < LANES; i++) begin
					res_q.moved[i] <= m_s5[i];
					if (kind_s5.last_point) begin
						res_q.box_min[i] <= sat(WIDE_W'(nmin[i]) - margin);
						res_q.box_max[i] <= sat(WIDE_W'(nmax[i]) + margin);
					end else begin
						res_q.box_min[i] <= '0;
						res_q.box_max[i] <= '0;
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

/* hw/rtl/rigid_transform_bounding_box_top.sv */
`timescale 1ns / 1ps

// Rotates each Q16.16 point by the configured quaternion (Q2.16, used as
// written, not normalized), adds the translation and returns the saturated
// point, one result item per input item. Points with tuser set grow a running
// box that starts at the origin; on the item with tlast the box, widened by
// box_margin on every side, comes out with m_tuser high and the box restarts.
// Rate: the back end is a six-stage pipeline with one shared stall, so it
// takes one item per clock while m_tready stays high. The two-entry front
// queue keeps s_tready high while it has room, also while the output is
// stalled. Configuration writes are always taken (cfg_ready is tied high)
// and should only occur while no item is in flight.
module rigid_transform_bounding_box_top import rtbb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_W-1:0]     cfg_data,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [95:0]            s_tdata,   // point_x, point_y, point_z
	input  logic                   s_tuser,   // include_in_box
	input  logic                   s_tlast,   // last_point
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [287:0]           m_tdata,   // moved_x/y/z, box_min_x/y/z, box_max_x/y/z
	output logic                   m_tuser    // box_valid
);

	cfg_t  cfg;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;
	res_t  res;

	assign cfg_ready = 1'b1;

	rtbb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rtbb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.in_include (s_tuser),
		.in_last    (s_tlast),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_item     (q_item)
	);

	rtbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {res.box_max, res.box_min, res.moved};
	assign m_tuser = res.box_valid;

	// an empty queue always has room
	assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> s_tready)
		else $error("front queue empty but not ready");

	// box fields are zero unless the box is emitted
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[287:96] == '0)
		else $error("box fields set without box_valid");

	// the box always holds the origin
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> $signed(m_tdata[127:96]) <= 0
			&& $signed(m_tdata[159:128]) <= 0 && $signed(m_tdata[191:160]) <= 0
			&& $signed(m_tdata[223:192]) >= 0 && $signed(m_tdata[255:224]) >= 0
			&& $signed(m_tdata[287:256]) >= 0)
		else $error("emitted box excludes the origin");

endmodule

/* test/rigid_transform_bounding_box_check.sv */
`timescale 1ns / 1ps

// Watches the configuration, input and result channels of the block, keeps its
// own copy of the registers and of the running box, predicts one result per
// accepted point and compares each accepted result with the oldest prediction.
module rigid_transform_bounding_box_check import rtbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [95:0]          s_tdata,
	input  logic                 s_tuser,
	input  logic                 s_tlast,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [287:0]         m_tdata,
	input  logic                 m_tuser,
	output int                   fail_count,
	output int                   pending
);

	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;

	string lane_name [LANES] = '{"x", "y", "z"};

	// register copy
	longint rot_w;
	longint rot_v [LANES];
	longint shift [LANES];
	longint margin;

	// running box
	longint box_lo [LANES];
	longint box_hi [LANES];

	res_t moved_q [$];
	int   mismatches;
	int   results_seen;

	function automatic longint round_q16(longint v);
		return (v + 64'sd32768) >>> FRAC_W;
	endfunction

	function automatic longint clamp_coord(longint v);
		if (v > COORD_MAX)
			return COORD_MAX;
		if (v < COORD_MIN)
			return COORD_MIN;
		return v;
	endfunction

	// v' = v + 2w(u x v) + 2u x (u x v), then shift, then saturate
	function automatic res_t place_point(logic [95:0] pt, logic inc, logic last);
		longint p [LANES];
		longint c [LANES];
		longint d [LANES];
		longint m [LANES];
		res_t   r;
		r = '0;
		for (int i = 0; i < LANES; i++)
			p[i] = longint'($signed(pt[32*i +: 32]));
		for (int i = 0; i < LANES; i++)
			c[i] = round_q16(rot_v[(i+1)%3] * p[(i+2)%3] - rot_v[(i+2)%3] * p[(i+1)%3]);
		for (int i = 0; i < LANES; i++)
			d[i] = rot_v[(i+1)%3] * c[(i+2)%3] - rot_v[(i+2)%3] * c[(i+1)%3];
		for (int i = 0; i < LANES; i++) begin
			m[i] = clamp_coord(round_q16(p[i] * 65536 + 2 * rot_w * c[i] + 2 * d[i]) + shift[i]);
			r.moved[i] = 32'(m[i]);
			if (inc) begin
				if (m[i] < box_lo[i])
					box_lo[i] = m[i];
				if (m[i] > box_hi[i])
					box_hi[i] = m[i];
			end
		end
		if (last) begin
			r.box_valid = 1'b1;
			for (int i = 0; i < LANES; i++) begin
				r.box_min[i] = 32'(clamp_coord(box_lo[i] - margin));
				r.box_max[i] = 32'(clamp_coord(box_hi[i] + margin));
				box_lo[i] = 0;
				box_hi[i] = 0;
			end
		end
		return r;
	endfunction

	function automatic res_t unpack_result(logic [287:0] d, logic u);
		res_t r;
		r.box_valid = u;
		for (int i = 0; i < LANES; i++) begin
			r.moved[i]   = d[32*i +: 32];
			r.box_min[i] = d[96 + 32*i +: 32];
			r.box_max[i] = d[192 + 32*i +: 32];
		end
		return r;
	endfunction

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %h (%0d) got %h (%0d)", results_seen, what,
					want, $signed(want), got, $signed(got));
		end
	endtask

	task automatic compare_result(res_t got);
		res_t want;
		if (moved_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d arrived with no point outstanding", results_seen);
		end else begin
			want = moved_q.pop_front();
			check_field("box_valid", 32'(want.box_valid), 32'(got.box_valid));
			for (int i = 0; i < LANES; i++) begin
				check_field({"moved_", lane_name[i]}, want.moved[i], got.moved[i]);
				check_field({"box_min_", lane_name[i]}, want.box_min[i], got.box_min[i]);
				check_field({"box_max_", lane_name[i]}, want.box_max[i], got.box_max[i]);
			end
		end
		results_seen++;
	endtask

	task automatic apply_write(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		case (idx)
			REG_QUAT_W:     rot_w    = longint'($signed(val[QUAT_W-1:0]));
			REG_QUAT_X:     rot_v[0] = longint'($signed(val[QUAT_W-1:0]));
			REG_QUAT_Y:     rot_v[1] = longint'($signed(val[QUAT_W-1:0]));
			REG_QUAT_Z:     rot_v[2] = longint'($signed(val[QUAT_W-1:0]));
			REG_SHIFT_X:    shift[0] = longint'($signed(val));
			REG_SHIFT_Y:    shift[1] = longint'($signed(val));
			REG_SHIFT_Z:    shift[2] = longint'($signed(val));
			REG_BOX_MARGIN: margin   = longint'({33'd0, val[MARGIN_W-1:0]});
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_w = longint'(QUAT_ONE);
			margin = 0;
			for (int i = 0; i < LANES; i++) begin
				rot_v[i] = 0;
				shift[i] = 0;
				box_lo[i] = 0;
				box_hi[i] = 0;
			end
			moved_q.delete();
			mismatches = 0;
			results_seen = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				moved_q.insert(moved_q.size(), place_point(s_tdata, s_tuser, s_tlast));
			if (m_tvalid && m_tready)
				compare_result(unpack_result(m_tdata, m_tuser));
			pending <= moved_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

/* test/rigid_transform_bounding_box_top_test.sv */
`timescale 1ns / 1ps

// Drives points and register writes into the block, stalls both sides at
// random and gives the verdict from the checker's failure and pending counts.
module rigid_transform_bounding_box_top_test;
	import rtbb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no item, write or result
	localparam int POINTS_PER_SETTING = 112;
	localparam int END_PAUSE = 20;

	// indexes the block has no register for; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd8;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hff;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0]   cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [95:0]          s_tdata;    // point_x, point_y, point_z
	logic                 s_tuser;    // include_in_box
	logic                 s_tlast;    // last_point
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [287:0]         m_tdata;    // moved_x/y/z, box_min_x/y/z, box_max_x/y/z
	logic                 m_tuser;    // box_valid

	int fail_count;
	int pending;
	int src_idle;      // percent of cycles the sender holds back
	int sink_idle;     // percent of cycles the receiver stalls
	int idle_cycles = 0;

	rigid_transform_bounding_box_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	rigid_transform_bounding_box_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls at the rate of the current phase
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle);
	end

	// watchdog: anything accepted on any channel restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Leaves cfg_valid high so that back-to-back writes need no second
	// assignment in one step; the caller drops it after the last write.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Unused upper bits of the quaternion and margin writes carry noise.
	task automatic load_setting(logic [QUAT_W-1:0] qw, logic [QUAT_W-1:0] qx,
			logic [QUAT_W-1:0] qy, logic [QUAT_W-1:0] qz, logic [COORD_W-1:0] sx,
			logic [COORD_W-1:0] sy, logic [COORD_W-1:0] sz, logic [MARGIN_W-1:0] mg);
		write_reg(REG_QUAT_W, {14'($urandom()), qw});
		write_reg(REG_QUAT_X, {14'($urandom()), qx});
		write_reg(REG_QUAT_Y, {14'($urandom()), qy});
		write_reg(REG_QUAT_Z, {14'($urandom()), qz});
		write_reg(REG_SHIFT_X, sx);
		write_reg(REG_SHIFT_Y, sy);
		write_reg(REG_SHIFT_Z, sz);
		write_reg(REG_BOX_MARGIN, {1'($urandom()), mg});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] small_signed(int unsigned half);
		return $urandom_range(2 * half) - half;
	endfunction

	task automatic random_setting();
		logic [QUAT_W-1:0]   q [4];
		logic [COORD_W-1:0]  sh [3];
		logic [MARGIN_W-1:0] mg;
		case ($urandom_range(2))
			0: begin
				// parts within +-0.5, length at most one, rotations that keep points in range
				for (int i = 0; i < 4; i++)
					q[i] = 18'(small_signed(32768));
			end
			1: begin
				for (int i = 0; i < 4; i++)
					q[i] = 18'($urandom());
			end
			default: begin
				q[0] = QUAT_ONE;
				for (int i = 1; i < 4; i++)
					q[i] = '0;
			end
		endcase
		for (int i = 0; i < 3; i++)
			sh[i] = ($urandom_range(3) == 0) ? $urandom() : small_signed(1 << 24);
		mg = ($urandom_range(4) == 0) ? 31'($urandom()) : 31'($urandom_range(1 << 20));
		load_setting(q[0], q[1], q[2], q[3], sh[0], sh[1], sh[2], mg);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0:       return 32'h7fff_ffff;
					1:       return 32'h8000_0000;
					2:       return 32'h0;
					default: return 32'hffff_ffff;
				endcase
			end
			1, 2:    return $urandom();
			default: return small_signed(1 << 22);
		endcase
	endfunction

	task automatic offer_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic inc, logic last);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {z, y, x};
		s_tuser  <= inc;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// wait until every predicted result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int set_len;
		int sent;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		s_tlast     = 1'b0;
		src_idle    = 16;
		sink_idle   = 53;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset values: identity, no shift, no margin
		offer_point(32'h0, 32'h0, 32'h0, 1'b1, 1'b1);                    // origin-only box
		offer_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 1'b1, 1'b0);
		offer_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 1'b1, 1'b0);
		offer_point(32'h1234_5678, 32'hffff_ffff, 32'h0, 1'b0, 1'b0);    // not in box
		offer_point(32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 1'b0, 1'b1); // last, left out
		offer_point(32'hffff_ffff, 32'h0000_0001, 32'h0000_8000, 1'b1, 1'b1);
		drain();

		// quaternion extremes, shifts at both limits, widest margin
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		load_setting(18'h20000, 18'h1ffff, 18'h20000, 18'h1ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'h7fff_ffff);
		offer_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0);
		offer_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
		offer_point(32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 1'b1, 1'b0);
		offer_point(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
		offer_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, 1'b1, 1'b1);
		drain();

		load_setting(18'h1ffff, 18'h20000, 18'h1ffff, 18'h20000,
			32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 31'd1);
		offer_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0);
		offer_point(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001, 1'b1, 1'b0);
		offer_point(32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0, 1'b1, 1'b1);
		drain();

		// quarter turn about z, modest shift and margin
		load_setting(18'd46341, 18'd0, 18'd0, 18'd46341,
			32'h0001_8000, 32'hfffe_0000, 32'h0, 31'h0001_0000);
		offer_point(32'h0001_0000, 32'h0, 32'h0, 1'b1, 1'b0);
		offer_point(32'h0, 32'h0001_0000, 32'h0, 1'b1, 1'b0);
		offer_point(32'hffff_8000, 32'h0000_4000, 32'h0002_0000, 1'b1, 1'b0);
		offer_point(32'h0003_0000, 32'hfffd_0000, 32'hffff_0000, 1'b1, 1'b1);

		// random sets under three idle patterns, a few settings in each
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				src_idle  = 53;
				sink_idle <= 16;
			end else if (phase == 2) begin
				src_idle  = 0;
				sink_idle <= 0;
			end
			for (int blk = 0; blk < 3; blk++) begin
				drain();
				random_setting();
				sent = 0;
				while (sent < POINTS_PER_SETTING) begin
					set_len = ($urandom_range(7) == 0) ? $urandom_range(13, 40)
						: $urandom_range(1, 12);
					for (int k = 0; k < set_len; k++) begin
						offer_point(pick_coord(), pick_coord(), pick_coord(),
							$urandom_range(3) != 0, k == set_len - 1);
						sent++;
					end
				end
			end
		end

		drain();
		repeat (END_PAUSE) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
